### rtl/grid_shortest_path_macros.svh
// ----------------------------------------------------------------------------
// Grid shortest path assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef GRID_SHORTEST_PATH_MACROS_SVH
`define GRID_SHORTEST_PATH_MACROS_SVH

// Same-cycle implication
`define GSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define GSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gsp_pkg.sv
// ----------------------------------------------------------------------------
// Grid shortest path package
// Opcodes, fixed field widths and RAM entry layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package gsp_pkg;

    localparam int TILE_W     = 8;
    localparam int TILE_CAP   = 256;
    localparam int DIST_W     = 16;
    localparam int COST_W     = 8;
    localparam int SLOT_W     = 3;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    localparam logic [DIST_W-1:0] UNREACHED = 16'hFFFF;
    localparam logic [DIST_W-1:0] SAT_MAX   = 16'hFFFE;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic REG_MAX_TRAVEL = 1'b0;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [TILE_W-1:0] from;
        logic              from_valid;
        logic              settled;
    } tile_entry_t;

    typedef struct packed {
        logic              valid;
        logic [COST_W-1:0] cost;
        logic [TILE_W-1:0] target;
    } edge_entry_t;

    localparam tile_entry_t TILE_INIT = '{distance: UNREACHED, from: '0, from_valid: 1'b0,
                                          settled: 1'b0};

endpackage

`default_nettype wire

### rtl/gsp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/grid_shortest_path.sv
// ----------------------------------------------------------------------------
// Grid shortest path
// Dijkstra search over a tile grid with edges and tile state held in RAM.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  s_*     | in  | tuser: opcode; tdata: tile, edge_slot, neighbor, weight,
//          |     |   edge_present, target, use_target
//  m_*     | out | tuser: done_res; tdata: distance, predecessor,
//          |     |   has_predecessor, reachable
//  apb     | cfg | register 0 at byte 0: max_travel
//
//  After reset a clearing pass zeroes the edge RAM and initialises the tile RAM;
//  no request is taken meanwhile. Load: edge write and result. Query: tile read
//  and report. Run: a tile clear pass, then for each picked tile a scan over the
//  tile RAM read port plus a read and check of each edge slot, then a report.
//  A request is taken only when idle and the result register is free or draining.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_shortest_path #(
    parameter int GRID_COLUMNS = 16,
    parameter int GRID_ROWS    = 16,
    parameter int MAX_EDGES    = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // stream in
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [7:0] tile, [10:8] edge_slot, [18:11] neighbor, [26:19] weight,
    // [27] edge_present, [35:28] target, [36] use_target, [39:37] zero
    input  wire logic [gsp_pkg::IN_DATA_W-1:0]   s_tdata,
    // [1:0] opcode
    input  wire logic [1:0]                      s_tuser,
    // stream out
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [15:0] distance, [23:16] predecessor, [24] has_predecessor,
    // [25] reachable, [31:26] zero
    output logic      [gsp_pkg::OUT_DATA_W-1:0]  m_tdata,
    // [0] done_res
    output logic                                 m_tuser,
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [2:0]                      paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);

    import gsp_pkg::*;

    localparam int NUM_TILES  = (GRID_COLUMNS * GRID_ROWS < TILE_CAP) ?
                                GRID_COLUMNS * GRID_ROWS : TILE_CAP;
    localparam int SW         = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EAW        = TILE_W + SW;
    localparam int EDEPTH     = 1 << EAW;
    localparam int KW         = $clog2(MAX_EDGES + 1);
    localparam logic [TILE_W:0] NT = (TILE_W+1)'(NUM_TILES);
    localparam logic [KW-1:0]   K_LAST = KW'(MAX_EDGES - 1);
    localparam logic [EAW:0]    CLR_LAST = (EAW+1)'(EDEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLR, ST_IDLE, ST_RCLR, ST_SCAN, ST_ERD, ST_ECHK, ST_UPD, ST_RWAIT
    } state_t;

    state_t              state_reg;
    logic [EAW:0]        clr_cnt_reg;
    logic [TILE_W:0]     scan_idx_reg;
    logic                scan_rv_reg;
    logic [TILE_W-1:0]   scan_tile_reg;
    logic                found_reg;
    logic [TILE_W-1:0]   best_idx_reg;
    tile_entry_t         best_ent_reg;
    logic [KW-1:0]       k_reg;
    edge_entry_t         edge_reg;
    logic [TILE_W-1:0]   src_reg;
    logic [TILE_W-1:0]   tgt_reg;
    logic                use_tgt_reg;
    logic                rep_done_reg;
    logic [15:0]         max_travel_reg;
    logic                m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                m_done_reg;

    // input fields
    logic [1:0]          in_opcode;
    logic [TILE_W-1:0]   in_tile, in_neighbor, in_target;
    logic [SLOT_W-1:0]   in_slot;
    logic [COST_W-1:0]   in_weight;
    logic                in_present, in_use_target;

    assign in_opcode     = s_tuser;
    assign in_tile       = s_tdata[7:0];
    assign in_slot       = s_tdata[10:8];
    assign in_neighbor   = s_tdata[18:11];
    assign in_weight     = s_tdata[26:19];
    assign in_present    = s_tdata[27];
    assign in_target     = s_tdata[35:28];
    assign in_use_target = s_tdata[36];

    // RAM ports
    logic              tile_we;
    logic [TILE_W-1:0] tile_waddr, tile_raddr;
    tile_entry_t       tile_wdata, tile_rdata;
    logic              edge_we;
    logic [EAW-1:0]    edge_waddr, edge_raddr;
    edge_entry_t       edge_wdata, edge_rdata;

    gsp_ram #(.WIDTH($bits(tile_entry_t)), .DEPTH(TILE_CAP)) u_tile_ram (
        .clk   (clk),
        .we    (tile_we),
        .waddr (tile_waddr),
        .wdata (tile_wdata),
        .raddr (tile_raddr),
        .rdata (tile_rdata)
    );

    gsp_ram #(.WIDTH($bits(edge_entry_t)), .DEPTH(EDEPTH)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    logic s_accept;
    logic out_free;
    logic m_set;
    logic scan_hit;
    logic scan_end;
    logic edge_last;
    logic edge_usable;
    logic [DIST_W:0]   sum_raw;
    logic [DIST_W-1:0] sum_sat;
    logic              better;
    logic              load_ok;
    logic              cfg_write;
    logic              rep_in_range;
    logic              rep_reach;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign s_accept  = s_tvalid && s_tready;
    assign m_set     = ((state_reg == ST_IDLE) && s_accept && (in_opcode == OP_LOAD))
                       || ((state_reg == ST_RWAIT) && out_free);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_done_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_MAX_TRAVEL) ? {16'd0, max_travel_reg} : 32'd0;

    assign scan_hit  = scan_rv_reg && !tile_rdata.settled
                       && (tile_rdata.distance != UNREACHED)
                       && (tile_rdata.distance < best_ent_reg.distance);
    assign scan_end  = (scan_idx_reg == NT) && !scan_rv_reg;
    assign edge_last = (k_reg == K_LAST);
    assign edge_usable = edge_rdata.valid && ({1'b0, edge_rdata.target} < NT);
    assign sum_raw   = {1'b0, best_ent_reg.distance} + (DIST_W+1)'(edge_reg.cost);
    assign sum_sat   = (sum_raw > {1'b0, SAT_MAX}) ? SAT_MAX : sum_raw[DIST_W-1:0];
    assign better    = tile_rdata.distance > sum_sat;
    assign load_ok   = ({1'b0, in_tile} < NT) && (32'(in_slot) < MAX_EDGES);
    assign rep_in_range = {1'b0, tgt_reg} < NT;
    assign rep_reach = rep_in_range && (tile_rdata.distance != UNREACHED)
                       && (tile_rdata.distance <= max_travel_reg);

    always_comb
    begin
        tile_we    = 1'b0;
        tile_waddr = best_idx_reg;
        tile_wdata = TILE_INIT;
        tile_raddr = tgt_reg;
        edge_we    = 1'b0;
        edge_waddr = {in_tile, SW'(in_slot)};
        edge_wdata = '{valid: in_present, cost: in_weight, target: in_neighbor};
        edge_raddr = {best_idx_reg, k_reg[SW-1:0]};
        case (state_reg)
            ST_CLR:
            begin
                edge_we    = 1'b1;
                edge_waddr = clr_cnt_reg[EAW-1:0];
                edge_wdata = '0;
                tile_we    = (clr_cnt_reg < (EAW+1)'(TILE_CAP));
                tile_waddr = clr_cnt_reg[TILE_W-1:0];
            end
            ST_IDLE:
            begin
                edge_we    = s_accept && (in_opcode == OP_LOAD) && load_ok;
                tile_raddr = (in_opcode == OP_QUERY) ? in_tile : in_target;
            end
            ST_RCLR:
            begin
                tile_we    = 1'b1;
                tile_waddr = clr_cnt_reg[TILE_W-1:0];
                if ((clr_cnt_reg[TILE_W-1:0] == src_reg) && ({1'b0, src_reg} < NT))
                begin
                    tile_wdata.distance = '0;
                end
            end
            ST_SCAN:
            begin
                // fetch the target at the end of a scan in case the run stops here
                tile_raddr = scan_end ? tgt_reg : scan_idx_reg[TILE_W-1:0];
                // settle the picked tile unless the run ends here
                if (scan_end && found_reg && !(use_tgt_reg && best_idx_reg == tgt_reg))
                begin
                    tile_we    = 1'b1;
                    tile_wdata = best_ent_reg;
                    tile_wdata.settled = 1'b1;
                end
            end
            ST_ECHK:
            begin
                tile_raddr = edge_rdata.target;
            end
            ST_UPD:
            begin
                tile_raddr = edge_reg.target;
                tile_we    = better;
                tile_waddr = edge_reg.target;
                tile_wdata = '{distance: sum_sat, from: best_idx_reg, from_valid: 1'b1,
                               settled: tile_rdata.settled};
            end
            ST_RWAIT:
            begin
                tile_raddr = tgt_reg;
            end
            default:
            begin
                tile_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            clr_cnt_reg    <= '0;
            scan_idx_reg   <= '0;
            scan_rv_reg    <= 1'b0;
            found_reg      <= 1'b0;
            k_reg          <= '0;
            max_travel_reg <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write && paddr[2] == REG_MAX_TRAVEL)
            begin
                max_travel_reg <= pwdata[15:0];
            end
            if (m_valid_reg && m_tready && !m_set)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == CLR_LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    clr_cnt_reg <= '0;
                    if (s_accept)
                    begin
                        src_reg      <= in_tile;
                        use_tgt_reg  <= in_use_target;
                        tgt_reg      <= (in_opcode == OP_QUERY) ? in_tile : in_target;
                        rep_done_reg <= (in_opcode == OP_RUN);
                        case (in_opcode)
                            OP_LOAD:
                            begin
                                m_valid_reg <= 1'b1;
                                m_data_reg  <= '0;
                                m_done_reg  <= 1'b1;
                            end
                            OP_RUN:   state_reg <= ST_RCLR;
                            OP_QUERY: state_reg <= ST_RWAIT;
                            default:  state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_RCLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == (EAW+1)'(TILE_CAP - 1))
                    begin
                        state_reg             <= ST_SCAN;
                        scan_idx_reg          <= '0;
                        scan_rv_reg           <= 1'b0;
                        found_reg             <= 1'b0;
                        best_ent_reg.distance <= UNREACHED;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_idx_reg != NT)
                    begin
                        scan_idx_reg  <= scan_idx_reg + 1'b1;
                        scan_tile_reg <= scan_idx_reg[TILE_W-1:0];
                        scan_rv_reg   <= 1'b1;
                    end
                    else
                    begin
                        scan_rv_reg <= 1'b0;
                    end
                    if (scan_hit)
                    begin
                        found_reg    <= 1'b1;
                        best_idx_reg <= scan_tile_reg;
                        best_ent_reg <= tile_rdata;
                    end
                    if (scan_end)
                    begin
                        k_reg <= '0;
                        if (!found_reg || (use_tgt_reg && best_idx_reg == tgt_reg))
                        begin
                            state_reg <= ST_RWAIT;
                        end
                        else
                        begin
                            state_reg <= ST_ERD;
                        end
                    end
                end
                ST_ERD:
                begin
                    state_reg <= ST_ECHK;
                end
                ST_ECHK, ST_UPD:
                begin
                    if (state_reg == ST_ECHK && edge_usable)
                    begin
                        edge_reg  <= edge_rdata;
                        state_reg <= ST_UPD;
                    end
                    else if (edge_last)
                    begin
                        state_reg             <= ST_SCAN;
                        scan_idx_reg          <= '0;
                        scan_rv_reg           <= 1'b0;
                        found_reg             <= 1'b0;
                        best_ent_reg.distance <= UNREACHED;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_ERD;
                    end
                end
                ST_RWAIT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_done_reg  <= rep_done_reg;
                        m_data_reg  <= {6'd0, rep_reach,
                                        rep_in_range && tile_rdata.from_valid,
                                        (rep_in_range && tile_rdata.from_valid) ?
                                            tile_rdata.from : 8'd0,
                                        rep_in_range ? tile_rdata.distance : UNREACHED};
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`include "grid_shortest_path_macros.svh"

    // a tile is settled at most once per run
    `GSP_ASSERT_NOW(a_settle_once, state_reg == ST_SCAN && tile_we, !best_ent_reg.settled, "settled tile picked again")
    // relaxation only ever lowers a distance
    `GSP_ASSERT_NOW(a_relax_lowers, state_reg == ST_UPD && tile_we, sum_sat < tile_rdata.distance && best_ent_reg.distance <= sum_sat, "relaxation did not lower distance")
    // a result appears only after a load or a report
    `GSP_ASSERT_NOW(a_result_source, $rose(m_valid_reg), $past(state_reg == ST_RWAIT) || $past(s_accept && in_opcode == OP_LOAD), "result without request")

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Grid shortest path testbench
// Loads edges, runs searches with and without an early stop, and queries tiles
// over the stream port with random bursts and stalls. Each request is mirrored
// by a scoreboard that holds its own copy of the graph and search state, and
// every result is compared field by field against the oldest expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import gsp_pkg::*;

    localparam int          NUM_TILES  = 256;
    localparam int          EDGE_SLOTS = 8;
    localparam int          CLUSTER    = 24;
    localparam int          ITEMS      = 900;
    localparam int          LIMIT      = 3000000;
    localparam logic [1:0]  OP_SPARE   = 2'd3;
    localparam logic [2:0]  ADDR_TRAVEL = 3'd4 * REG_MAX_TRAVEL;
    localparam logic [2:0]  ADDR_SPARE = 3'd4;

    typedef struct packed {
        logic              done;
        logic              reach;
        logic              has_pred;
        logic [TILE_W-1:0] pred;
        logic [DIST_W-1:0] distance;
    } path_result_t;

    // ------------------------------------------------------------------------
    class path_scoreboard;
        logic [TILE_W-1:0] edge_to   [NUM_TILES*EDGE_SLOTS];
        logic [COST_W-1:0] edge_wt   [NUM_TILES*EDGE_SLOTS];
        bit                edge_on   [NUM_TILES*EDGE_SLOTS];
        logic [DIST_W-1:0] dist_of   [NUM_TILES];
        logic [TILE_W-1:0] from_of   [NUM_TILES];
        bit                from_on   [NUM_TILES];
        bit                done_of   [NUM_TILES];
        logic [DIST_W-1:0] travel;
        path_result_t      expected_q[$];
        int                mismatches;
        int                unexpected;

        function new();
            for (int e = 0; e < NUM_TILES*EDGE_SLOTS; e++)
                edge_on[e] = 0;
            clear_search();
            travel     = '0;
            mismatches = 0;
            unexpected = 0;
        endfunction

        function void clear_search();
            for (int i = 0; i < NUM_TILES; i++)
            begin
                dist_of[i] = UNREACHED;
                from_of[i] = '0;
                from_on[i] = 0;
                done_of[i] = 0;
            end
        endfunction

        function void search(int src, int tgt, bit stop_at_tgt);
            int pick;
            int pick_d;
            int e;
            int n;
            int sum;
            clear_search();
            dist_of[src] = '0;
            forever
            begin
                pick   = -1;
                pick_d = UNREACHED;
                // strict compare in index order gives the lowest tile on a tie
                for (int i = 0; i < NUM_TILES; i++)
                    if (!done_of[i] && dist_of[i] != UNREACHED && dist_of[i] < pick_d)
                    begin
                        pick_d = dist_of[i];
                        pick   = i;
                    end
                if (pick < 0 || (stop_at_tgt && pick == tgt))
                    return;
                done_of[pick] = 1;
                for (int k = 0; k < EDGE_SLOTS; k++)
                begin
                    e = pick * EDGE_SLOTS + k;
                    if (!edge_on[e])
                        continue;
                    n   = edge_to[e];
                    sum = pick_d + edge_wt[e];
                    if (sum > SAT_MAX)
                        sum = SAT_MAX;
                    if (dist_of[n] > sum)
                    begin
                        dist_of[n] = sum;
                        from_of[n] = pick;
                        from_on[n] = 1;
                    end
                end
            end
        endfunction

        function path_result_t tile_report(int t, bit done);
            path_result_t r;
            r.distance = dist_of[t];
            r.pred     = from_on[t] ? from_of[t] : '0;
            r.has_pred = from_on[t];
            r.reach    = (dist_of[t] != UNREACHED) && (dist_of[t] <= travel);
            r.done     = done;
            return r;
        endfunction

        function void note_request(logic [1:0] op, logic [IN_DATA_W-1:0] d);
            path_result_t r;
            int           e;
            e = d[7:0] * EDGE_SLOTS + d[10:8];
            if (op == OP_LOAD)
            begin
                edge_to[e] = d[18:11];
                edge_wt[e] = d[26:19];
                edge_on[e] = d[27];
                r          = '0;
                r.done     = 1'b1;
                expected_q.insert(expected_q.size(), r);
            end
            else if (op == OP_RUN)
            begin
                search(d[7:0], d[35:28], d[36]);
                expected_q.insert(expected_q.size(), tile_report(d[35:28], 1'b1));
            end
            else if (op == OP_QUERY)
                expected_q.insert(expected_q.size(), tile_report(d[7:0], 1'b0));
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d, logic u);
            path_result_t exp_r;
            bit           bad;
            if (expected_q.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected result: tdata=%h tuser=%b", d, u);
                return;
            end
            exp_r = expected_q.pop_front();
            bad   = (d[15:0] !== exp_r.distance) || (d[23:16] !== exp_r.pred) ||
                    (d[24] !== exp_r.has_pred) || (d[25] !== exp_r.reach) ||
                    (u !== exp_r.done) || (d[31:26] !== '0);
            if (bad)
            begin
                mismatches++;
                if (mismatches + unexpected <= 10)
                    $display({"mismatch: exp dist=%0d pred=%0d hp=%b reach=%b done=%b",
                              " | got dist=%0d pred=%0d hp=%b reach=%b done=%b"},
                             exp_r.distance, exp_r.pred, exp_r.has_pred, exp_r.reach,
                             exp_r.done, d[15:0], d[23:16], d[24], d[25], u);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass
    // ------------------------------------------------------------------------

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    path_scoreboard sb = new();
    int             cycles = 0;
    int             burst_left = 0;
    int             ready_pct = 100;
    int             sent = 0;
    int             runs = 0;

    grid_shortest_path u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    // result side: check, then pick the next stall pattern
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        if (cycles % 300 == 0)
            case ($urandom_range(0, 3))
                0, 1: ready_pct = 100;
                2:    ready_pct = 60;
                default: ready_pct = 20;
            endcase
        m_tready <= ($urandom_range(0, 99) < ready_pct);
    end

    always @(posedge clk)
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("testbench: done, errors");
            $finish;
        end

    function automatic logic [IN_DATA_W-1:0] pack_item(int tile, int slot, int nb, int w,
                                                       bit pres, int tgt, bit ut);
        return {3'b000, ut, tgt[7:0], pres, w[7:0], nb[7:0], slot[2:0], tile[7:0]};
    endfunction

    task automatic send(logic [1:0] op, logic [IN_DATA_W-1:0] d);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(op, d);
        if (op != OP_SPARE)
            sent++;
        if (op == OP_RUN)
            runs++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_TRAVEL)
            sb.travel = value[15:0];
    endtask

    // mostly a dense cluster so that searches stay short, sometimes any tile
    task automatic send_random();
        int  pick;
        int  hi;
        pick = $urandom_range(0, 99);
        hi   = ($urandom_range(0, 19) == 0) ? NUM_TILES - 1 : CLUSTER - 1;
        if (pick < 55)
            send(OP_LOAD, pack_item($urandom_range(0, CLUSTER - 1), $urandom_range(0, 7),
                 $urandom_range(0, hi), $urandom_range(0, 255),
                 $urandom_range(0, 9) != 0, $urandom_range(0, 255), $urandom_range(0, 1)));
        else if (pick < 60)
            send(OP_LOAD, pack_item($urandom_range(0, 255), $urandom_range(0, 7),
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1),
                 $urandom_range(0, 255), $urandom_range(0, 1)));
        else if (pick < 62)
            send(OP_RUN, pack_item($urandom_range(0, CLUSTER - 1), $urandom_range(0, 7),
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1),
                 $urandom_range(0, hi), $urandom_range(0, 9) < 7));
        else if (pick < 63)
            send(OP_SPARE, pack_item($urandom_range(0, 255), 0, 0, 0, 0, 0, 0));
        else
            send(OP_QUERY, pack_item($urandom_range(0, hi), $urandom_range(0, 7),
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1),
                 $urandom_range(0, 255), $urandom_range(0, 1)));
    endtask

    initial
    begin
        logic [31:0] travel_set [6];
        travel_set = '{32'd0, 32'd65534, 32'd65535, 32'd0, 32'd300, 32'd0};
        travel_set[3] = $urandom_range(0, 65534);
        travel_set[5] = $urandom_range(0, 2000);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 6; ph++)
        begin
            apb_write(ADDR_TRAVEL, travel_set[ph]);
            if (ph == 1)
                apb_write(ADDR_SPARE, 32'hFFFF_FFFF);
            if (ph == 0)
            begin
                // extremes of slot, weight and tile, then a removed edge
                send(OP_LOAD, pack_item(0, 0, 1, 0, 1, 0, 0));
                send(OP_LOAD, pack_item(0, 7, 2, 255, 1, 255, 1));
                send(OP_LOAD, pack_item(1, 3, 2, 1, 1, 0, 0));
                send(OP_LOAD, pack_item(2, 0, 255, 10, 1, 0, 0));
                send(OP_LOAD, pack_item(255, 7, 0, 5, 1, 0, 0));
                send(OP_LOAD, pack_item(3, 1, 4, 7, 1, 0, 0));
                send(OP_LOAD, pack_item(3, 1, 4, 7, 0, 0, 0));
                send(OP_RUN, pack_item(0, 0, 0, 0, 0, 255, 0));
                send(OP_QUERY, pack_item(0, 0, 0, 0, 0, 0, 0));
                send(OP_QUERY, pack_item(2, 0, 0, 0, 0, 0, 0));
                send(OP_QUERY, pack_item(255, 0, 0, 0, 0, 0, 0));
                send(OP_QUERY, pack_item(3, 0, 0, 0, 0, 0, 0));
                // early stop: target read out but left unsettled
                send(OP_RUN, pack_item(0, 0, 0, 0, 0, 2, 1));
                send(OP_QUERY, pack_item(255, 0, 0, 0, 0, 0, 0));
                send(OP_SPARE, pack_item(7, 0, 0, 0, 0, 0, 0));
                send(OP_RUN, pack_item(255, 0, 0, 0, 0, 2, 1));
                send(OP_QUERY, pack_item(1, 0, 0, 0, 0, 0, 0));
                send(OP_RUN, pack_item(4, 0, 0, 0, 0, 4, 1));
                send(OP_QUERY, pack_item(4, 0, 0, 0, 0, 0, 0));
            end
            while (sent < (ph + 1) * ITEMS / 6)
                send_random();
            drain();
        end

        $display("covered %0d requests including %0d searches over six max_travel settings",
                 sent, runs);
        $display("%0d mismatches, %0d unexpected results, %0d outstanding",
                 sb.mismatches, sb.unexpected, sb.pending());
        if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
